// File: sv/tsa_pkg.sv
// Shared types and constants for the two-row slot allocator.
// Field layout of the stream beats, operation and register codes.
// No dependencies; imported by every module of the block except tsa_ram.
package tsa_pkg;

    // Input beat layout (tdata, lowest bit first): operation, slot, card
    localparam int OP_W        = 3;
    localparam int SLOT_FLD_W  = 6;
    localparam int CARD_FLD_W  = 8;
    localparam int OP_LSB      = 0;
    localparam int SLOT_LSB    = OP_LSB + OP_W;
    localparam int CARD_LSB    = SLOT_LSB + SLOT_FLD_W;
    localparam int IN_TDATA_W  = 24;

    // Output beat layout: ok, slot_out, free_count, lift_entrance, lift_exit
    localparam int FREE_FLD_W  = 7;
    localparam int OUT_TDATA_W = 16;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int HALF_W      = 6;
    localparam int EMP_W       = 9;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_COUNT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EMPLOYEE_COUNT = 1'b1;

    localparam int              HALF_COUNT_RESET = 32;
    localparam logic [EMP_W-1:0] EMP_RESET       = 9'd256;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TAKE_ENTRANCE = 3'd0;
    localparam logic [OP_W-1:0] OP_TAKE_EXIT     = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE       = 3'd2;
    localparam logic [OP_W-1:0] OP_CLAIM         = 3'd3;
    localparam logic [OP_W-1:0] OP_CARD_ENTER    = 3'd4;
    localparam logic [OP_W-1:0] OP_CARD_EXIT     = 3'd5;

    // Status from the column unit to the sequencer
    typedef struct packed {
        logic found;     // checked column has a free slot
        logic chk_last;  // checked column is the last of the scan
        logic iss_last;  // issued column is the last of the scan
    } scan_stat_t;

endpackage

// File: sv/tsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the slot map banks and the card presence map.
module tsa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: sv/tsa_col_unit.sv
// Column evaluator shared by both scan directions: read addresses of the
// issued column, step to the next column, and the free-slot decision.
// Depends on tsa_pkg.
module tsa_col_unit #(
    parameter int ROW_MAX = 32
) (
    input  logic                                          exit_dir,
    input  logic [$clog2(ROW_MAX+1)-1:0]                  h,
    input  logic [((ROW_MAX > 1) ? $clog2(ROW_MAX) : 1)-1:0] iss_col,
    input  logic [((ROW_MAX > 1) ? $clog2(ROW_MAX) : 1)-1:0] chk_col,
    input  logic                                          front_used,
    input  logic                                          back_used,
    output logic [$clog2(2*ROW_MAX)-1:0]                  front_addr,
    output logic [$clog2(2*ROW_MAX)-1:0]                  back_addr,
    output logic [((ROW_MAX > 1) ? $clog2(ROW_MAX) : 1)-1:0] iss_next,
    output logic [$clog2(2*ROW_MAX)-1:0]                  got,
    output tsa_pkg::scan_stat_t                           stat
);
    import tsa_pkg::*;

    localparam int SLOT_AW = $clog2(2*ROW_MAX);
    localparam int COL_W   = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;

    logic iss_at_top;
    logic chk_at_top;

    // Issued column: front slot c, back slot c + h
    assign front_addr = SLOT_AW'(iss_col);
    assign back_addr  = SLOT_AW'(iss_col) + SLOT_AW'(h);
    assign iss_next   = exit_dir ? (iss_col - COL_W'(1)) : (iss_col + COL_W'(1));

    // End of scan: column 0 going down, column h-1 going up
    assign iss_at_top = ((COL_W+1)'(iss_col) + (COL_W+1)'(1)) == (COL_W+1)'(h);
    assign chk_at_top = ((COL_W+1)'(chk_col) + (COL_W+1)'(1)) == (COL_W+1)'(h);

    // Checked column: front row wins over back row
    always_comb begin
        stat.found    = !front_used || !back_used;
        stat.iss_last = exit_dir ? (iss_col == '0) : iss_at_top;
        stat.chk_last = exit_dir ? (chk_col == '0) : chk_at_top;
        if (!front_used) begin
            got = SLOT_AW'(chk_col);
        end else begin
            got = SLOT_AW'(chk_col) + SLOT_AW'(h);
        end
    end

endmodule

// File: sv/two_row_slot_allocator_core.sv
// Two-row slot allocator: a sequencer steps one column evaluator over a
// used/free map of 2*h slots (front row c, back row c+h) and a card
// presence map. A take operation scans one column per clock through the two
// slot map read ports. Release, claim and card operations take one RAM read,
// one decision and one write-back; the write-back of every operation waits
// for a free output register. s_tready is high only while the block is idle;
// a finished result sits in the output register and the next beat can be
// accepted meanwhile. After reset the block clears both maps; a write of
// half_count clears the slot map. s_tready stays low during both sweeps.
// Depends on tsa_pkg, tsa_ram and tsa_col_unit.
module two_row_slot_allocator_core #(
    parameter int ROW_MAX  = 32,
    parameter int CARD_MAX = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input beats
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tsa_pkg::IN_TDATA_W-1:0]    s_tdata,   // operation, slot, card
    // Result beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // ok, slot_out, free_count, lift_entrance, lift_exit
    output logic [tsa_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // Configuration writes
    input  logic                              cfg_wr_en,
    input  logic [tsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tsa_pkg::*;

    localparam int SLOT_DEPTH = 2 * ROW_MAX;
    localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
    localparam int COL_W      = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
    localparam int ROW_W      = $clog2(ROW_MAX + 1);
    localparam int FREE_W     = ROW_W + 1;
    localparam int CARD_AW    = (CARD_MAX > 1) ? $clog2(CARD_MAX) : 1;
    localparam int CLR_DEPTH  = (SLOT_DEPTH > CARD_MAX) ? SLOT_DEPTH : CARD_MAX;
    localparam int CLR_W      = $clog2(CLR_DEPTH);
    localparam int H_RESET    = (ROW_MAX < HALF_COUNT_RESET) ? ROW_MAX : HALF_COUNT_RESET;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_LOOK   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    // Control state
    logic [2:0]            state_reg, state_next;
    logic [ROW_W-1:0]      h_reg, h_next;
    logic [EMP_W-1:0]      emp_reg, emp_next;
    logic [FREE_W-1:0]     free_reg, free_next;
    logic [CLR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                  clr_cards_reg, clr_cards_next;
    logic                  iss_live_reg, iss_live_next;
    logic                  chk_live_reg, chk_live_next;
    logic                  out_valid_reg, out_valid_next;

    // Payload
    logic [OP_W-1:0]       op_reg, op_next;
    logic [SLOT_FLD_W-1:0] slot_reg, slot_next;
    logic [CARD_FLD_W-1:0] card_reg, card_next;
    logic [COL_W-1:0]      iss_col_reg, iss_col_next;
    logic [COL_W-1:0]      chk_col_reg, chk_col_next;
    logic                  res_ok_reg, res_ok_next;
    logic [SLOT_AW-1:0]    res_slot_reg, res_slot_next;
    logic                  res_le_reg, res_le_next;
    logic                  res_lx_reg, res_lx_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // Input fields
    logic [OP_W-1:0]       in_op;
    logic [SLOT_FLD_W-1:0] in_slot;
    logic [CARD_FLD_W-1:0] in_card;

    // Memory ports
    logic                  slot_wr_en;
    logic [SLOT_AW-1:0]    slot_wr_addr;
    logic                  slot_wr_data;
    logic [SLOT_AW-1:0]    slot_rd_a_addr;
    logic                  slot_rd_a;
    logic                  slot_rd_b;
    logic                  card_wr_en;
    logic [CARD_AW-1:0]    card_wr_addr;
    logic                  card_wr_data;
    logic                  card_rd;

    // Column unit
    logic [SLOT_AW-1:0]    front_addr;
    logic [SLOT_AW-1:0]    back_addr;
    logic [COL_W-1:0]      iss_step;
    logic [SLOT_AW-1:0]    scan_got;
    scan_stat_t            scan_stat;

    // Misc
    logic                  in_accept;
    logic                  out_free;
    logic [FREE_W-1:0]     two_h;
    logic                  slot_in_range;
    logic                  card_valid;
    logic                  clr_done;
    logic [HALF_W-1:0]     cfg_half;
    logic [ROW_W-1:0]      cfg_h_eff;

    assign in_op   = s_tdata[OP_LSB +: OP_W];
    assign in_slot = s_tdata[SLOT_LSB +: SLOT_FLD_W];
    assign in_card = s_tdata[CARD_LSB +: CARD_FLD_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign two_h         = FREE_W'({h_reg, 1'b0});
    assign slot_in_range = 32'(slot_reg) < 32'(two_h);
    assign card_valid    = (32'(card_reg) < 32'(emp_reg)) && (32'(card_reg) < CARD_MAX);

    // half_count clamped into [1, ROW_MAX]
    assign cfg_half = cfg_wdata[HALF_W-1:0];
    always_comb begin
        if (cfg_half == '0) begin
            cfg_h_eff = ROW_W'(1);
        end else if (32'(cfg_half) > ROW_MAX) begin
            cfg_h_eff = ROW_W'(ROW_MAX);
        end else begin
            cfg_h_eff = ROW_W'(cfg_half);
        end
    end

    // Slot map: two identical banks give the front and back reads of a column
    assign slot_rd_a_addr = (state_reg == ST_IDLE) ? SLOT_AW'(in_slot) : front_addr;

    tsa_ram #(.WIDTH(1), .DEPTH(SLOT_DEPTH)) u_slot_front (
        .aclk    (aclk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_addr (slot_rd_a_addr),
        .rd_data (slot_rd_a)
    );

    tsa_ram #(.WIDTH(1), .DEPTH(SLOT_DEPTH)) u_slot_back (
        .aclk    (aclk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_addr (back_addr),
        .rd_data (slot_rd_b)
    );

    // Card presence map, read at the card of the incoming beat
    tsa_ram #(.WIDTH(1), .DEPTH(CARD_MAX)) u_card_map (
        .aclk    (aclk),
        .wr_en   (card_wr_en),
        .wr_addr (card_wr_addr),
        .wr_data (card_wr_data),
        .rd_addr (CARD_AW'(in_card)),
        .rd_data (card_rd)
    );

    tsa_col_unit #(.ROW_MAX(ROW_MAX)) u_col (
        .exit_dir   (op_reg == OP_TAKE_EXIT),
        .h          (h_reg),
        .iss_col    (iss_col_reg),
        .chk_col    (chk_col_reg),
        .front_used (slot_rd_a),
        .back_used  (slot_rd_b),
        .front_addr (front_addr),
        .back_addr  (back_addr),
        .iss_next   (iss_step),
        .got        (scan_got),
        .stat       (scan_stat)
    );

    assign clr_done = clr_cards_reg ? (32'(clr_cnt_reg) == CLR_DEPTH - 1)
                                    : (32'(clr_cnt_reg) == SLOT_DEPTH - 1);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        h_next         = h_reg;
        emp_next       = emp_reg;
        free_next      = free_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_cards_next = clr_cards_reg;
        iss_live_next  = iss_live_reg;
        chk_live_next  = chk_live_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        slot_next      = slot_reg;
        card_next      = card_reg;
        iss_col_next   = iss_col_reg;
        chk_col_next   = chk_col_reg;
        res_ok_next    = res_ok_reg;
        res_slot_next  = res_slot_reg;
        res_le_next    = res_le_reg;
        res_lx_next    = res_lx_reg;
        out_data_next  = out_data_reg;
        slot_wr_en     = 1'b0;
        slot_wr_addr   = res_slot_reg;
        slot_wr_data   = 1'b0;
        card_wr_en     = 1'b0;
        card_wr_addr   = CARD_AW'(card_reg);
        card_wr_data   = 1'b0;

        // Result register drains independently
        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // Sweep zeros through the maps
            ST_CLEAR: begin
                slot_wr_en   = 32'(clr_cnt_reg) < SLOT_DEPTH;
                slot_wr_addr = SLOT_AW'(clr_cnt_reg);
                card_wr_en   = clr_cards_reg && (32'(clr_cnt_reg) < CARD_MAX);
                card_wr_addr = CARD_AW'(clr_cnt_reg);
                if (clr_done) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    op_next       = in_op;
                    slot_next     = in_slot;
                    card_next     = in_card;
                    chk_live_next = 1'b0;
                    iss_live_next = 1'b1;
                    if (in_op == OP_TAKE_EXIT) begin
                        iss_col_next = COL_W'(h_reg - ROW_W'(1));
                        state_next   = ST_SCAN;
                    end else if (in_op == OP_TAKE_ENTRANCE) begin
                        iss_col_next = '0;
                        state_next   = ST_SCAN;
                    end else begin
                        state_next = ST_LOOK;
                    end
                end
            end
            // One column issued and one checked per cycle
            ST_SCAN: begin
                chk_col_next  = iss_col_reg;
                chk_live_next = iss_live_reg;
                if (iss_live_reg) begin
                    iss_col_next  = iss_step;
                    iss_live_next = !scan_stat.iss_last;
                end
                res_le_next = 1'b0;
                res_lx_next = 1'b0;
                if (chk_live_reg) begin
                    if (scan_stat.found) begin
                        res_ok_next   = 1'b1;
                        res_slot_next = scan_got;
                        state_next    = ST_FINISH;
                    end else if (scan_stat.chk_last) begin
                        res_ok_next   = 1'b0;
                        res_slot_next = '0;
                        state_next    = ST_FINISH;
                    end
                end
            end
            // Single-entry operations: decide on the word read at accept
            ST_LOOK: begin
                res_ok_next   = 1'b0;
                res_slot_next = '0;
                res_le_next   = 1'b0;
                res_lx_next   = 1'b0;
                case (op_reg)
                    OP_RELEASE: begin
                        if (slot_in_range && slot_rd_a) begin
                            res_ok_next   = 1'b1;
                            res_slot_next = SLOT_AW'(slot_reg);
                        end
                    end
                    OP_CLAIM: begin
                        if (slot_in_range && !slot_rd_a) begin
                            res_ok_next   = 1'b1;
                            res_slot_next = SLOT_AW'(slot_reg);
                        end
                    end
                    OP_CARD_ENTER: begin
                        if (card_valid && !card_rd) begin
                            res_ok_next = 1'b1;
                            res_le_next = 1'b1;
                        end
                    end
                    OP_CARD_EXIT: begin
                        if (card_valid && card_rd) begin
                            res_ok_next = 1'b1;
                            res_lx_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                state_next = ST_FINISH;
            end
            // Write back, update the count and hand over the result
            ST_FINISH: begin
                if (out_free) begin
                    if (res_ok_reg) begin
                        case (op_reg)
                            OP_TAKE_ENTRANCE, OP_TAKE_EXIT, OP_CLAIM: begin
                                slot_wr_en   = 1'b1;
                                slot_wr_data = 1'b1;
                                if (free_reg != '0) begin
                                    free_next = free_reg - FREE_W'(1);
                                end
                            end
                            OP_RELEASE: begin
                                slot_wr_en   = 1'b1;
                                slot_wr_data = 1'b0;
                                if (free_reg < two_h) begin
                                    free_next = free_reg + FREE_W'(1);
                                end
                            end
                            OP_CARD_ENTER: begin
                                card_wr_en   = 1'b1;
                                card_wr_data = 1'b1;
                            end
                            OP_CARD_EXIT: begin
                                card_wr_en   = 1'b1;
                                card_wr_data = 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                    out_data_next  = {res_lx_reg, res_le_reg, FREE_FLD_W'(free_next),
                                      SLOT_FLD_W'(res_slot_reg), res_ok_reg};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes; half_count frees every slot again
        if (cfg_wr_en) begin
            if (cfg_index == REG_HALF_COUNT) begin
                h_next         = cfg_h_eff;
                free_next      = FREE_W'({cfg_h_eff, 1'b0});
                clr_cnt_next   = '0;
                clr_cards_next = (state_reg == ST_CLEAR) && clr_cards_reg;
                state_next     = ST_CLEAR;
            end else if (cfg_index == REG_EMPLOYEE_COUNT) begin
                emp_next = cfg_wdata[EMP_W-1:0];
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            h_reg         <= ROW_W'(H_RESET);
            emp_reg       <= EMP_RESET;
            free_reg      <= FREE_W'(2 * H_RESET);
            clr_cnt_reg   <= '0;
            clr_cards_reg <= 1'b1;
            iss_live_reg  <= 1'b0;
            chk_live_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            emp_reg       <= emp_next;
            free_reg      <= free_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_cards_reg <= clr_cards_next;
            iss_live_reg  <= iss_live_next;
            chk_live_reg  <= chk_live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        slot_reg     <= slot_next;
        card_reg     <= card_next;
        iss_col_reg  <= iss_col_next;
        chk_col_reg  <= chk_col_next;
        res_ok_reg   <= res_ok_next;
        res_slot_reg <= res_slot_next;
        res_le_reg   <= res_le_next;
        res_lx_reg   <= res_lx_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: verif/tsa_result_checker.sv
`timescale 1ns / 100ps
// Result checker for two_row_slot_allocator_core. It mirrors the slot map, the card
// map and both registers, predicts each result beat and compares results in order.
// Depends on tsa_pkg only.
module tsa_result_checker #(
    parameter int ROW_MAX  = 32,
    parameter int CARD_MAX = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [tsa_pkg::IN_TDATA_W-1:0]  s_tdata,   // operation, slot, card
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // ok, slot_out, free_count, lift_entrance, lift_exit
    input  logic [tsa_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [tsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              mismatches,
    output int                              outstanding
);
    import tsa_pkg::*;

    // Result beat layout, lowest bit first
    localparam int OK_BIT   = 0;
    localparam int SOUT_LSB = 1;
    localparam int FREE_LSB = SOUT_LSB + SLOT_FLD_W;
    localparam int LE_BIT   = FREE_LSB + FREE_FLD_W;
    localparam int LX_BIT   = LE_BIT + 1;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic                  ok;
        logic [SLOT_FLD_W-1:0] slot_out;
        logic [FREE_FLD_W-1:0] free_count;
        logic                  lift_entrance;
        logic                  lift_exit;
    } alloc_result_t;

    // Mirrored block state
    logic              slot_used   [2*ROW_MAX];
    logic              card_inside [CARD_MAX];
    int unsigned       free_slots;
    logic [HALF_W-1:0] half_reg;
    logic [EMP_W-1:0]  emp_reg;
    alloc_result_t     pending_results[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Slots per row after clamping into [1, ROW_MAX]
    function automatic int unsigned row_len();
        if (half_reg == 0) return 1;
        if (half_reg > ROW_MAX) return ROW_MAX;
        return 32'(half_reg);
    endfunction

    function automatic void clear_slot_map();
        for (int i = 0; i < 2*ROW_MAX; i++) slot_used[i] = 1'b0;
        free_slots = 2 * row_len();
    endfunction

    function automatic void occupy(input int unsigned idx);
        slot_used[idx] = 1'b1;
        if (free_slots > 0) free_slots--;
    endfunction

    // One operation against the mirrored state; returns the result beat it gives
    function automatic alloc_result_t predict_grant(input logic [OP_W-1:0] op,
                                                    input logic [SLOT_FLD_W-1:0] slot,
                                                    input logic [CARD_FLD_W-1:0] card);
        alloc_result_t res;
        int unsigned   h;
        int unsigned   col;
        bit            card_ok;
        res     = '0;
        h       = row_len();
        card_ok = (card < emp_reg) && (card < CARD_MAX);
        case (op)
            OP_TAKE_ENTRANCE, OP_TAKE_EXIT: begin
                // column scan, front row before back row in each column
                for (int k = 0; k < h && !res.ok; k++) begin
                    col = (op == OP_TAKE_ENTRANCE) ? k : h - 1 - k;
                    if (!slot_used[col]) begin
                        res.ok       = 1'b1;
                        res.slot_out = col[SLOT_FLD_W-1:0];
                    end else if (!slot_used[col + h]) begin
                        res.ok       = 1'b1;
                        res.slot_out = SLOT_FLD_W'(col + h);
                    end
                end
                if (res.ok) occupy(32'(res.slot_out));
            end
            OP_RELEASE: begin
                if (slot < 2*h && slot_used[slot]) begin
                    slot_used[slot] = 1'b0;
                    if (free_slots < 2*h) free_slots++;
                    res.ok       = 1'b1;
                    res.slot_out = slot;
                end
            end
            OP_CLAIM: begin
                if (slot < 2*h && !slot_used[slot]) begin
                    occupy(32'(slot));
                    res.ok       = 1'b1;
                    res.slot_out = slot;
                end
            end
            OP_CARD_ENTER: begin
                if (card_ok && !card_inside[card]) begin
                    card_inside[card] = 1'b1;
                    res.ok            = 1'b1;
                    res.lift_entrance = 1'b1;
                end
            end
            OP_CARD_EXIT: begin
                if (card_ok && card_inside[card]) begin
                    card_inside[card] = 1'b0;
                    res.ok            = 1'b1;
                    res.lift_exit     = 1'b1;
                end
            end
            default: ;
        endcase
        res.free_count = free_slots[FREE_FLD_W-1:0];
        return res;
    endfunction

    task automatic flag_result(input string why, input alloc_result_t want,
                               input alloc_result_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display({"%0t: %s: expected ok=%0d slot=%0d free=%0d le=%0d lx=%0d, ",
                      "got ok=%0d slot=%0d free=%0d le=%0d lx=%0d"},
                     $time, why, want.ok, want.slot_out, want.free_count,
                     want.lift_entrance, want.lift_exit, got.ok, got.slot_out,
                     got.free_count, got.lift_entrance, got.lift_exit);
    endtask

    // Watch both channels and the config port at every rising edge
    always @(posedge aclk) begin : watch
        alloc_result_t want;
        alloc_result_t got;
        if (!aresetn) begin
            half_reg = HALF_W'(HALF_COUNT_RESET);
            emp_reg  = EMP_RESET;
            for (int i = 0; i < CARD_MAX; i++) card_inside[i] = 1'b0;
            clear_slot_map();
            pending_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.ok            = m_tdata[OK_BIT];
                got.slot_out      = m_tdata[SOUT_LSB +: SLOT_FLD_W];
                got.free_count    = m_tdata[FREE_LSB +: FREE_FLD_W];
                got.lift_entrance = m_tdata[LE_BIT];
                got.lift_exit     = m_tdata[LX_BIT];
                if (pending_results.size() == 0) begin
                    flag_result("result beat with nothing pending", '0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.ok != want.ok || got.slot_out != want.slot_out ||
                        got.free_count != want.free_count ||
                        got.lift_entrance != want.lift_entrance ||
                        got.lift_exit != want.lift_exit)
                        flag_result("result mismatch", want, got);
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == REG_HALF_COUNT) begin
                    half_reg = cfg_wdata[HALF_W-1:0];
                    clear_slot_map();
                end else if (cfg_index == REG_EMPLOYEE_COUNT) begin
                    emp_reg = cfg_wdata[EMP_W-1:0];
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_grant(s_tdata[OP_LSB +: OP_W],
                                                        s_tdata[SLOT_LSB +: SLOT_FLD_W],
                                                        s_tdata[CARD_LSB +: CARD_FLD_W]));
        end
        outstanding <= pending_results.size();
    end

endmodule

// File: verif/tb_two_row_slot_allocator_core.sv
`timescale 1ns / 100ps
// Testbench top for two_row_slot_allocator_core: clock, reset, register writes and
// input beats (directed, then random phases with idling); gives the verdict.
// Depends on tsa_pkg, two_row_slot_allocator_core and tsa_result_checker.
module tb_two_row_slot_allocator_core;
    import tsa_pkg::*;

    localparam int ROW_MAX       = 32;
    localparam int CARD_MAX      = 256;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 104;

    // Codes the block does not decode
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int          mismatches;
    int          outstanding;
    int          cycles = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned rows;
    int unsigned emp_now;

    // Register settings per random phase, extremes included
    int unsigned half_set [PHASES] = '{63, 0, 2, 32, 7, 1, 16, 5};
    int unsigned emp_set  [PHASES] = '{256, 0, 511, 100, 200, 256, 37, 255};

    two_row_slot_allocator_core #(
        .ROW_MAX  (ROW_MAX),
        .CARD_MAX (CARD_MAX)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tsa_result_checker #(
        .ROW_MAX  (ROW_MAX),
        .CARD_MAX (CARD_MAX)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side back-pressure
    always @(negedge aclk) begin
        if (aresetn)
            m_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // One input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [SLOT_FLD_W-1:0] slot,
                             input logic [CARD_FLD_W-1:0] card);
        logic [IN_TDATA_W-1:0] word;
        word                         = '0;
        word[OP_LSB +: OP_W]         = op;
        word[SLOT_LSB +: SLOT_FLD_W] = slot;
        word[CARD_LSB +: CARD_FLD_W] = card;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Block idle: every result back and ready for beats
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0 || !s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        wait_idle();
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        // give the block time to start its slot map sweep
        repeat (2) @(negedge aclk);
        if (idx == REG_HALF_COUNT) begin
            rows = 32'(value[HALF_W-1:0]);
            if (rows == 0) rows = 1;
            if (rows > ROW_MAX) rows = ROW_MAX;
        end else begin
            emp_now = 32'(value[EMP_W-1:0]);
        end
    endtask

    initial begin : stimulus
        int unsigned pick;
        int          edge_card;
        logic [OP_W-1:0]       op;
        logic [SLOT_FLD_W-1:0] slot;
        logic [CARD_FLD_W-1:0] card;

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rows           = HALF_COUNT_RESET;
        emp_now        = 32'(EMP_RESET);
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, reset settings: search order, used and free slots, cards
        send_beat(OP_TAKE_ENTRANCE, 6'd0, 8'd0);
        send_beat(OP_TAKE_EXIT, 6'd63, 8'd255);
        send_beat(OP_CLAIM, 6'd0, 8'd0);
        send_beat(OP_CLAIM, 6'd32, 8'd0);
        send_beat(OP_RELEASE, 6'd5, 8'd0);
        send_beat(OP_RELEASE, 6'd0, 8'd0);
        send_beat(OP_RELEASE, 6'd63, 8'd0);
        send_beat(OP_CLAIM, 6'd63, 8'd0);
        send_beat(OP_CARD_ENTER, 6'd0, 8'd0);
        send_beat(OP_CARD_ENTER, 6'd0, 8'd0);
        send_beat(OP_CARD_EXIT, 6'd0, 8'd255);
        send_beat(OP_CARD_ENTER, 6'd63, 8'd255);
        send_beat(OP_CARD_EXIT, 6'd63, 8'd255);
        send_beat(OP_CARD_EXIT, 6'd0, 8'd0);
        send_beat(OP_SPARE_LO, 6'd63, 8'd255);
        send_beat(OP_SPARE_HI, 6'd63, 8'd255);

        // Directed, one slot per row: nothing free, out of range, no valid card
        write_reg(REG_HALF_COUNT, 1);
        write_reg(REG_EMPLOYEE_COUNT, 0);
        send_beat(OP_TAKE_ENTRANCE, 6'd0, 8'd0);
        send_beat(OP_TAKE_EXIT, 6'd0, 8'd0);
        send_beat(OP_TAKE_EXIT, 6'd0, 8'd0);
        send_beat(OP_TAKE_ENTRANCE, 6'd0, 8'd0);
        send_beat(OP_CLAIM, 6'd2, 8'd0);
        send_beat(OP_RELEASE, 6'd2, 8'd0);
        send_beat(OP_RELEASE, 6'd1, 8'd0);
        send_beat(OP_CARD_ENTER, 6'd0, 8'd0);

        // Random phases, one register setting and one idling mode each
        for (int p = 0; p < PHASES; p++) begin
            write_reg(REG_HALF_COUNT, half_set[p]);
            write_reg(REG_EMPLOYEE_COUNT, emp_set[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (int n = 0; n < PHASE_BEATS; n++) begin
                slot = SLOT_FLD_W'($urandom);
                card = CARD_FLD_W'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 22)      op = OP_TAKE_ENTRANCE;
                else if (pick < 40) op = OP_TAKE_EXIT;
                else if (pick < 55) op = OP_RELEASE;
                else if (pick < 70) op = OP_CLAIM;
                else if (pick < 83) op = OP_CARD_ENTER;
                else if (pick < 96) op = OP_CARD_EXIT;
                else                op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
                // slot mostly in range, card mostly from a small pool or the limit
                if ((op == OP_RELEASE || op == OP_CLAIM) && $urandom_range(0, 99) < 85)
                    slot = SLOT_FLD_W'($urandom_range(0, 2*rows - 1));
                if (op == OP_CARD_ENTER || op == OP_CARD_EXIT) begin
                    case ($urandom_range(0, 3))
                        0, 1: card = CARD_FLD_W'($urandom_range(0, 15));
                        2: begin
                            edge_card = int'(emp_now) - 1 + int'($urandom_range(0, 1));
                            if (edge_card > 255) edge_card = 255;
                            if (edge_card < 0) edge_card = 0;
                            card = edge_card[CARD_FLD_W-1:0];
                        end
                        default: ;
                    endcase
                end
                send_beat(op, slot, card);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
